@@ sv/sia_pkg.sv @@
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types, codes and sizes for the slot index allocator.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = 10;
    localparam int PTR_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = PTR_W + 1;
    localparam int CFG_W     = 11;
    localparam int PROD_W    = IDX_W + CFG_W;
    localparam int ADDR_W    = 64;
    localparam int MODE_W    = 3;
    localparam int STAT_W    = 2;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;

    localparam logic [CFG_W-1:0] CAPACITY_RST  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] DESC_SIZE_RST = CFG_W'(32);

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 3'd0,
        MODE_FREE   = 3'd1,
        MODE_RESET  = 3'd2,
        MODE_HOST   = 3'd3,
        MODE_DEVICE = 3'd4
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_CAPACITY  = 2'd0,
        REG_DESC_SIZE = 2'd1,
        REG_CPU_BASE  = 2'd2,
        REG_GPU_BASE  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0]  capacity;
        logic [CFG_W-1:0]  desc_size;
        logic [ADDR_W-1:0] cpu_base;
        logic [ADDR_W-1:0] gpu_base;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

@@ sv/sia_regs.sv @@
// ----------------------------------------------------------------------------
// sia_regs
// APB configuration registers: capacity, descriptor size and both bases.
// ----------------------------------------------------------------------------
module sia_regs
    import sia_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    reg_idx_t sel;
    logic     wr_en;

    assign sel   = reg_idx_t'(paddr[4:3]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity  <= CAPACITY_RST;
            cfg_reg.desc_size <= DESC_SIZE_RST;
            cfg_reg.cpu_base  <= '0;
            cfg_reg.gpu_base  <= '0;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_CAPACITY:  cfg_reg.capacity  <= pwdata[CFG_W-1:0];
                REG_DESC_SIZE: cfg_reg.desc_size <= pwdata[CFG_W-1:0];
                REG_CPU_BASE:  cfg_reg.cpu_base  <= pwdata;
                REG_GPU_BASE:  cfg_reg.gpu_base  <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_CAPACITY:  prdata = PDATA_W'(cfg_reg.capacity);
            REG_DESC_SIZE: prdata = PDATA_W'(cfg_reg.desc_size);
            REG_CPU_BASE:  prdata = cfg_reg.cpu_base;
            REG_GPU_BASE:  prdata = cfg_reg.gpu_base;
            default:       prdata = '0;
        endcase
    end

endmodule

@@ sv/sia_ctrl.sv @@
// ----------------------------------------------------------------------------
// sia_ctrl
// Request sequencer: capture, execute against the queue, hand to output.
// ----------------------------------------------------------------------------
module sia_ctrl
    import sia_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_EXEC;
            S_EXEC:  state_next = S_DONE;
            S_DONE:  if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:  cmd.exec = 1'b1;
            S_DONE:  cmd.load = stat.out_free;
            default: ;
        endcase
    end

endmodule

@@ sv/sia_datapath.sv @@
// ----------------------------------------------------------------------------
// sia_datapath
// Free FIFO, bump counter, address multiply-add and output register.
// ----------------------------------------------------------------------------
module sia_datapath
    import sia_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_cmd_t           cmd,
    output dp_stat_t           stat,
    input  cfg_t               cfg,
    input  logic [MODE_W-1:0]  mode,
    input  logic [IDX_W-1:0]   slot_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAT_W-1:0]  status,
    output logic [IDX_W-1:0]   granted_index,
    output logic [ADDR_W-1:0]  address
);

    logic [IDX_W-1:0]  mem [MAX_SLOTS];

    logic [MODE_W-1:0] mode_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  tail_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  fresh_reg;
    logic [IDX_W-1:0]  rd_reg;
    logic [IDX_W-1:0]  gr_reg;
    logic              from_mem_reg;
    status_t           st_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [IDX_W-1:0]  granted_reg;
    logic [ADDR_W-1:0] address_reg;

    logic [CNT_W-1:0]  cap_eff;
    logic              mem_we;
    logic              mem_re;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  tail_inc;
    logic [ADDR_W-1:0] addr_next;

    assign cap_eff  = (cfg.capacity > CFG_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                         : CNT_W'(cfg.capacity);
    assign head_inc = (head_reg == PTR_W'(MAX_SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(MAX_SLOTS - 1)) ? '0 : tail_reg + 1'b1;

    assign mem_re = cmd.exec && (mode_reg == MODE_ALLOC) && (count_reg != '0);
    assign mem_we = cmd.exec && (mode_reg == MODE_FREE)
                    && (CNT_W'(idx_reg) < cap_eff)
                    && (count_reg != CNT_W'(MAX_SLOTS));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[tail_reg] <= idx_reg;
        if (mem_re)
            rd_reg <= mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
        end
        else if (cmd.exec)
        begin
            unique case (mode_reg)
                MODE_ALLOC:
                begin
                    if (count_reg != '0)
                    begin
                        head_reg  <= head_inc;
                        count_reg <= count_reg - 1'b1;
                    end
                    else if (fresh_reg < cap_eff)
                        fresh_reg <= fresh_reg + 1'b1;
                end
                MODE_FREE:
                begin
                    if (mem_we)
                    begin
                        tail_reg  <= tail_inc;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                MODE_RESET:
                begin
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    count_reg <= '0;
                    fresh_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // per-request working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            idx_reg  <= slot_index;
        end
        if (cmd.exec)
        begin
            st_reg       <= ST_OK;
            gr_reg       <= '0;
            from_mem_reg <= 1'b0;
            prod_reg     <= PROD_W'(idx_reg) * PROD_W'(cfg.desc_size);
            unique case (mode_reg)
                MODE_ALLOC:
                begin
                    if (count_reg != '0)
                        from_mem_reg <= 1'b1;
                    else if (fresh_reg >= cap_eff)
                        st_reg <= ST_OVERFLOW;
                    else
                        gr_reg <= fresh_reg[IDX_W-1:0];
                end
                MODE_FREE:
                begin
                    if (CNT_W'(idx_reg) >= cap_eff)
                        st_reg <= ST_RANGE;
                    else if (count_reg == CNT_W'(MAX_SLOTS))
                        st_reg <= ST_FULL;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_HOST:   addr_next = cfg.cpu_base + ADDR_W'(prod_reg);
            MODE_DEVICE: addr_next = cfg.gpu_base + ADDR_W'(prod_reg);
            default:     addr_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg  <= st_reg;
            granted_reg <= from_mem_reg ? rd_reg : gr_reg;
            address_reg <= addr_next;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign address       = address_reg;

endmodule

@@ sv/slot_index_allocator.sv @@
// ----------------------------------------------------------------------------
// slot_index_allocator
// Hands out slot indices from a free FIFO or a bump counter, and forms
// host and device addresses of slots; freed indices go back to the FIFO.
//
// Request channel: in_valid/in_ready with mode and slot_index. One result
// beat per request on out_valid/out_ready: status, granted_index, address.
// A request is captured in the accepting cycle, the execute state updates
// the queue (FIFO memory read or write, counter step, stride multiply) and
// the done state loads the result into the output register. in_ready is
// low in the execute and done states, so no new request is taken until
// the current result has been loaded into the output register.
// When the output register is still held by a stalled receiver, the
// finished request waits in the done state and no new request is taken.
// Reset empties the FIFO and the counter at once (no clearing pass) and
// loads capacity 1024, descriptor size 32, both bases zero. Registers are
// written through the APB port at byte addresses 0, 8, 16 and 24; the user
// must write them only while the block is idle; the block has no guard.
// ----------------------------------------------------------------------------
module slot_index_allocator
    import sia_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [MODE_W-1:0]  mode,
    input  logic [IDX_W-1:0]   slot_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAT_W-1:0]  status,
    output logic [IDX_W-1:0]   granted_index,
    output logic [ADDR_W-1:0]  address
);

    cfg_t     cfg;
    ctl_cmd_t cmd;
    dp_stat_t stat;

    assign pready = 1'b1;

    sia_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    sia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sia_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg           (cfg),
        .mode          (mode),
        .slot_index    (slot_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_index (granted_index),
        .address       (address)
    );

endmodule

@@ sv/sia_checker.sv @@
// ----------------------------------------------------------------------------
// sia_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sia_checker
    import sia_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [STAT_W-1:0]  status,
    input logic [IDX_W-1:0]   granted_index,
    input logic [ADDR_W-1:0]  address
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in flight");

    a_overflow_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OVERFLOW) |-> granted_index == '0)
        else $error("overflow with non-zero index");

    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> address == '0)
        else $error("failed request with address");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a request in flight");

endmodule

bind slot_index_allocator sia_checker u_sia_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_index (granted_index),
    .address       (address)
);
